/* hdl/rraes_pkg.sv */
// Package: constants, types and round functions for the reduced-round AES unit.
`timescale 1ns / 1ps
package rraes_pkg;
   localparam int ROUNDS = 5;
   localparam int KEY_WORDS = 2 * (ROUNDS + 1);
   localparam int SLOT_W = 4;
   localparam int STAGES = ROUNDS + 1;
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_ENCRYPT = 1'b1;

   typedef logic [127:0] state_type;
   typedef logic [7:0] byte_type;

   localparam byte_type SBOX [256] = '{
   8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
   8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
   8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
   8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
   8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
   8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
   8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
   8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
   8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
   8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
   8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
   8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
   8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
   8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
   8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
   8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic byte_type xtime(input byte_type b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic state_type sub_shift(input state_type s);
      state_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
         end
      end
      sub_shift = t;
   endfunction

   function automatic state_type mix_columns(input state_type s);
      state_type t;
      byte_type a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         a0 = s[32*c +: 8];
         a1 = s[32*c+8 +: 8];
         a2 = s[32*c+16 +: 8];
         a3 = s[32*c+24 +: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         t[32*c +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
         t[32*c+8 +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         t[32*c+16 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         t[32*c+24 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      mix_columns = t;
   endfunction
endpackage

/* hdl/rraes_if.sv */
// Interfaces: request and response channels.
`timescale 1ns / 1ps
interface rraes_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic [3:0] key_slot;
   logic [63:0] key_word;
   logic [63:0] block_lo;
   logic [63:0] block_hi;
   modport source (output valid, mode, key_slot, key_word, block_lo, block_hi, input ready);
   modport sink (input valid, mode, key_slot, key_word, block_lo, block_hi, output ready);
endinterface

interface rraes_rsp_if;
   logic valid;
   logic ready;
   logic [63:0] cipher_lo;
   logic [63:0] cipher_hi;
   modport source (output valid, cipher_lo, cipher_hi, input ready);
   modport sink (input valid, cipher_lo, cipher_hi, output ready);
endinterface

/* hdl/rraes_keys.sv */
// Round key store: twelve 64-bit words written by load transfers.
`timescale 1ns / 1ps
module rraes_keys
   import rraes_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic wr_en,
   input  logic [SLOT_W-1:0] wr_slot,
   input  logic [63:0] wr_data,
   output state_type round_key [STAGES]
);
   logic [63:0] key_ff [KEY_WORDS];
   logic [63:0] key_in [KEY_WORDS];

   always_comb begin
      key_in = key_ff;
      if (wr_en && 32'(wr_slot) < KEY_WORDS) begin
         key_in[wr_slot] = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_WORDS; i++) key_ff[i] <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   always_comb begin
      for (int r = 0; r < STAGES; r++) begin
         round_key[r] = {key_ff[2*r+1], key_ff[2*r]};
      end
   end
endmodule

/* hdl/rraes_round.sv */
// One pipelined cipher round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
`timescale 1ns / 1ps
module rraes_round
   import rraes_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic mix_en,
   input  logic in_valid,
   input  state_type in_state,
   input  state_type round_key,
   output logic out_valid,
   output state_type out_state
);
   logic valid_ff;
   state_type state_ff;
   state_type state_in;
   state_type shifted;

   always_comb begin
      shifted = sub_shift(in_state);
      state_in = (mix_en ? mix_columns(shifted) : shifted) ^ round_key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
endmodule

/* hdl/reduced_round_aes_encrypt_unit.sv */
// Top level: reduced-round AES encrypt pipeline with independent round keys.
// Throughput: one block per cycle while the pipeline does not hold; whitening stage then one register stage per round.
// The whole pipeline holds when the output stage is full and rsp.ready is low.
// Load transfers wait until the pipeline is empty, write the key store and leave no result.
// Synchronous active-high reset clears all valid bits and zeros every round key word.
`timescale 1ns / 1ps
module reduced_round_aes_encrypt_unit
   import rraes_pkg::*;
(
   input  logic clock,
   input  logic reset,
   rraes_req_if.sink req,
   rraes_rsp_if.source rsp
);
   state_type round_key [STAGES];
   logic advance;
   logic busy;
   logic req_fire;
   logic valid_ff;
   state_type white_ff;
   logic stage_valid [STAGES];
   state_type stage_state [STAGES];

   // Hold the whole line while the last stage waits on the sink.
   assign advance = !stage_valid[STAGES-1] || rsp.ready;

   always_comb begin
      busy = 1'b0;
      for (int r = 0; r < STAGES; r++) busy = busy | stage_valid[r];
   end

   // Hold a load until the line drains so blocks in flight keep their round keys.
   assign req.ready = advance && !(req.mode == MODE_LOAD && busy);
   assign req_fire = req.valid && req.ready;

   rraes_keys u_keys (
      .clock(clock), .reset(reset),
      .wr_en(req_fire && req.mode == MODE_LOAD),
      .wr_slot(req.key_slot), .wr_data(req.key_word),
      .round_key(round_key)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= req_fire && req.mode == MODE_ENCRYPT;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         white_ff <= {req.block_hi, req.block_lo} ^ round_key[0];
      end
   end

   assign stage_valid[0] = valid_ff;
   assign stage_state[0] = white_ff;

   for (genvar r = 1; r < STAGES; r++) begin : g_round
      rraes_round u_round (
         .clock(clock), .reset(reset), .advance(advance),
         .mix_en(r != ROUNDS),
         .in_valid(stage_valid[r-1]), .in_state(stage_state[r-1]),
         .round_key(round_key[r]),
         .out_valid(stage_valid[r]), .out_state(stage_state[r])
      );
   end

   assign rsp.valid = stage_valid[STAGES-1];
   assign rsp.cipher_lo = stage_state[STAGES-1][63:0];
   assign rsp.cipher_hi = stage_state[STAGES-1][127:64];

`ifndef ASSERT_OFF
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.cipher_lo))
      else $error("result changed during stall");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !busy |-> req.ready)
      else $error("input blocked with empty pipeline");
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.mode == MODE_LOAD |=> !valid_ff)
      else $error("load produced a result");
`endif
endmodule
